// ----- rtl/core/gwm_pkg.sv -----
// Package for the glob wildcard matcher: symbol codes, counter limits and the
// structs shared by the position cells, the output buffer and the top level.
// No dependencies.
package gwm_pkg;

  localparam int unsigned SYM_W      = 8;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [SYM_W-1:0]   SYM_STAR     = 8'd42;
  localparam logic [SYM_W-1:0]   SYM_QUESTION = 8'd63;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hFFFF;

  // Broadcast from the top level to every position cell.
  typedef struct packed {
    logic             fresh;  // active set is the start set of a new candidate
    logic             step;   // a candidate character is consumed this cycle
    logic             clr;    // a new pattern begins, drop all stored positions
    logic [SYM_W-1:0] sym;    // the character of the accepted transaction
  } gwm_ctrl_t;

  // Handed from one cell to its right-hand neighbor.
  typedef struct packed {
    logic fwd;        // this position matched the character, next one goes active
    logic star_pass;  // this position is an active star, next one goes active too
    logic is_star;    // this position holds a star
  } gwm_link_t;

  // One result, packed with the last field in the lowest bit.
  typedef struct packed {
    logic               pattern_overflow;
    logic [COUNT_W-1:0] match_count;
    logic [COUNT_W-1:0] candidate_index;
    logic               matched;
  } gwm_result_t;

endpackage

// ----- rtl/core/gwm_cell.sv -----
// One pattern position of the matcher chain: the stored character and its
// active bit. Depends on gwm_pkg.
module gwm_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  gwm_pkg::gwm_ctrl_t ctrl,
  input  logic              wr_en,
  input  logic              start,
  input  gwm_pkg::gwm_link_t link_i,
  output gwm_pkg::gwm_link_t link_o,
  output logic              act_nxt
);
  import gwm_pkg::*;

  logic             valid_r;
  logic             act_r;
  logic             star_r;
  logic             any_r;
  logic [SYM_W-1:0] sym_r;
  logic             cur;
  logic             raw;

  // A fresh candidate starts from the closed start set instead of the register.
  assign cur = ctrl.fresh ? start : act_r;
  // A star keeps itself active; a matching left neighbor activates this one.
  assign raw     = (valid_r & star_r & cur) | link_i.fwd;
  assign act_nxt = raw | link_i.star_pass;

  assign link_o.fwd       = valid_r & ~star_r & cur & (any_r | (sym_r == ctrl.sym));
  assign link_o.star_pass = valid_r & star_r & raw;
  assign link_o.is_star   = valid_r & star_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      act_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r <= 1'b1;
      end else if (ctrl.clr) begin
        valid_r <= 1'b0;
      end
      if (ctrl.step) begin
        act_r <= act_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sym_r  <= ctrl.sym;
      star_r <= (ctrl.sym == SYM_STAR);
      any_r  <= (ctrl.sym == SYM_QUESTION);
    end
  end

endmodule

// ----- rtl/core/gwm_out_buf.sv -----
// Output register with one skid entry for the matcher results.
// Depends on gwm_pkg.
module gwm_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  gwm_pkg::gwm_result_t push_data,
  output logic                 push_ready,
  output logic                 out_valid,
  output gwm_pkg::gwm_result_t out_data,
  input  logic                 out_ready
);
  import gwm_pkg::*;

  logic        out_vld_r, out_vld_nxt;
  logic        skid_vld_r, skid_vld_nxt;
  gwm_result_t out_dat_r, out_dat_nxt;
  gwm_result_t skid_dat_r, skid_dat_nxt;
  logic        take;

  assign take       = out_vld_r & out_ready;
  assign push_ready = ~skid_vld_r;
  assign out_valid  = out_vld_r;
  assign out_data   = out_dat_r;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_dat_nxt  = out_dat_r;
    skid_dat_nxt = skid_dat_r;
    if (skid_vld_r) begin
      if (take) begin
        out_dat_nxt  = skid_dat_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (push) begin
      if (out_vld_r && !take) begin
        skid_dat_nxt = push_data;
        skid_vld_nxt = 1'b1;
      end else begin
        out_dat_nxt = push_data;
        out_vld_nxt = 1'b1;
      end
    end else if (take) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_dat_r  <= out_dat_nxt;
    skid_dat_r <= skid_dat_nxt;
  end

endmodule

// ----- rtl/core/glob_wildcard_matcher_core.sv -----
// Top level of the glob wildcard matcher: a chain of position cells, the
// pattern load control, the counters and the result buffer.
// Depends on gwm_pkg, gwm_cell and gwm_out_buf.
//
// Usage. One input stream carries both the pattern and the candidate strings,
// one character per transaction. in_tuser is 0 for a pattern character and 1
// for a candidate character; in_tlast marks the final character of either.
// A pattern character that follows a finished pattern (or reset) starts a new
// pattern and clears both counters. '*' matches any run of characters and '?'
// matches exactly one. Characters beyond PATTERN_MAX are dropped and flagged.
// Each candidate's last character yields one result transaction on the output
// stream: matched flag, candidate index, running match count, overflow flag.
// Throughput is one input transaction per clock cycle while in_tready is high,
// set by the update of the active bits that every cell hands to its right-hand
// neighbor. A result is registered after its last character is taken.
// When the receiver stalls, one more result is held in a skid entry; in_tready
// drops only while that entry is full. Reset clears all control state and the
// counters; no pattern is loaded, so no candidate matches until one is.
// Runs of stars are stored as a single star, which keeps each cell's update
// to its immediate neighbors.
module glob_wildcard_matcher_core #(
  parameter int unsigned PATTERN_MAX = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [gwm_pkg::SYM_W-1:0]        in_tdata,   // [7:0] symbol
  input  logic                             in_tuser,   // [0] mode
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] matched, [16:1] candidate_index, [32:17] match_count,
  // [33] pattern_overflow, [39:34] zero
  output logic [gwm_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import gwm_pkg::*;

  localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int unsigned IDX_W = $clog2(PATTERN_MAX);

  logic               loading_r, loading_nxt;
  logic               fresh_r, fresh_nxt;
  logic               ovf_r, ovf_nxt;
  logic               last_star_r, last_star_nxt;
  logic [LEN_W-1:0]   raw_len_r, raw_len_nxt;
  logic [LEN_W-1:0]   comp_len_r, comp_len_nxt;
  logic [COUNT_W-1:0] cand_cnt_r, cand_cnt_nxt;
  logic [COUNT_W-1:0] match_cnt_r, match_cnt_nxt;

  logic               in_acc, pat_acc, cand_acc, new_pat, sym_star;
  logic [LEN_W-1:0]   len_base, comp_base;
  logic               last_star_base;
  logic               pat_wr;
  logic [IDX_W-1:0]   wr_idx;
  logic               hit;
  logic               res_push;
  gwm_result_t        res, out_res;
  gwm_ctrl_t          ctrl;
  gwm_link_t          link [PATTERN_MAX:0];
  logic [PATTERN_MAX:0] act_nxt;

  assign in_acc   = in_tvalid & in_tready;
  assign pat_acc  = in_acc & ~in_tuser;
  assign cand_acc = in_acc & in_tuser;
  assign new_pat  = pat_acc & ~loading_r;
  assign sym_star = (in_tdata == SYM_STAR);

  assign len_base       = new_pat ? '0 : raw_len_r;
  assign comp_base      = new_pat ? '0 : comp_len_r;
  assign last_star_base = new_pat ? 1'b0 : last_star_r;
  assign wr_idx         = comp_base[IDX_W-1:0];

  assign ctrl.fresh = fresh_r;
  assign ctrl.step  = cand_acc;
  assign ctrl.clr   = new_pat;
  assign ctrl.sym   = in_tdata;

  // The chain of position cells; the end position after the last cell only
  // collects what the last cell hands over.
  assign link[0] = '0;

  for (genvar gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
    logic start;
    if (gi == 0) begin : g_first
      assign start = 1'b1;
    end else if (gi == 1) begin : g_second
      assign start = link[1].is_star;
    end else begin : g_rest
      assign start = 1'b0;
    end

    gwm_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .wr_en   (pat_wr && (wr_idx == IDX_W'(gi))),
      .start   (start),
      .link_i  (link[gi]),
      .link_o  (link[gi+1]),
      .act_nxt (act_nxt[gi])
    );
  end

  assign act_nxt[PATTERN_MAX] = link[PATTERN_MAX].fwd | link[PATTERN_MAX].star_pass;

  // The candidate matches when the position just past the pattern is active.
  assign hit = act_nxt[comp_len_r];

  always_comb begin
    loading_nxt   = loading_r;
    fresh_nxt     = fresh_r;
    ovf_nxt       = ovf_r;
    last_star_nxt = last_star_r;
    raw_len_nxt   = raw_len_r;
    comp_len_nxt  = comp_len_r;
    cand_cnt_nxt  = cand_cnt_r;
    match_cnt_nxt = match_cnt_r;
    pat_wr        = 1'b0;
    if (pat_acc) begin
      loading_nxt   = ~in_tlast;
      fresh_nxt     = 1'b1;
      ovf_nxt       = new_pat ? 1'b0 : ovf_r;
      cand_cnt_nxt  = new_pat ? '0 : cand_cnt_r;
      match_cnt_nxt = new_pat ? '0 : match_cnt_r;
      raw_len_nxt   = len_base;
      comp_len_nxt  = comp_base;
      last_star_nxt = last_star_base;
      if (len_base < LEN_W'(PATTERN_MAX)) begin
        raw_len_nxt = len_base + LEN_W'(1);
        // A star right after a stored star adds nothing and is not stored.
        if (!(sym_star && last_star_base)) begin
          pat_wr        = 1'b1;
          comp_len_nxt  = comp_base + LEN_W'(1);
          last_star_nxt = sym_star;
        end
      end else begin
        ovf_nxt = 1'b1;
      end
    end else if (cand_acc) begin
      loading_nxt = 1'b0;
      fresh_nxt   = in_tlast;
      if (in_tlast) begin
        if (cand_cnt_r != COUNT_MAX) begin
          cand_cnt_nxt = cand_cnt_r + COUNT_W'(1);
        end
        if (hit && (match_cnt_r != COUNT_MAX)) begin
          match_cnt_nxt = match_cnt_r + COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loading_r   <= 1'b0;
      fresh_r     <= 1'b1;
      ovf_r       <= 1'b0;
      last_star_r <= 1'b0;
      raw_len_r   <= '0;
      comp_len_r  <= '0;
      cand_cnt_r  <= '0;
      match_cnt_r <= '0;
    end else begin
      loading_r   <= loading_nxt;
      fresh_r     <= fresh_nxt;
      ovf_r       <= ovf_nxt;
      last_star_r <= last_star_nxt;
      raw_len_r   <= raw_len_nxt;
      comp_len_r  <= comp_len_nxt;
      cand_cnt_r  <= cand_cnt_nxt;
      match_cnt_r <= match_cnt_nxt;
    end
  end

  assign res_push                 = cand_acc & in_tlast;
  assign res.matched              = hit;
  assign res.candidate_index      = cand_cnt_r;
  assign res.match_count          = match_cnt_nxt;
  assign res.pattern_overflow     = ovf_r;

  gwm_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_push),
    .push_data  (res),
    .push_ready (in_tready),
    .out_valid  (out_tvalid),
    .out_data   (out_res),
    .out_ready  (out_tready)
  );

  assign out_tdata = {{(OUT_DATA_W - $bits(gwm_result_t)){1'b0}}, out_res};

endmodule

// ----- rtl/core/gwm_chk.sv -----
// Port-level checker for the glob wildcard matcher, bound to the top level.
// Depends on gwm_pkg and glob_wildcard_matcher_core.
module gwm_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [gwm_pkg::SYM_W-1:0]        in_tdata,
  input logic                             in_tuser,
  input logic                             in_tlast,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [gwm_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import gwm_pkg::*;

  logic [COUNT_W:0] idx_plus_one;
  logic             in_seen;

  assign idx_plus_one = {1'b0, out_tdata[16:1]} + 17'd1;
  assign in_seen      = |in_tdata;

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed while stalled");

  // A result appears only after a candidate's last character was taken.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tuser && in_tlast))
    else $error("result without a finished candidate");

  // Matches can never outnumber the candidates seen.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, out_tdata[32:17]} <= idx_plus_one))
    else $error("match count exceeds candidate count");

  // A matching candidate is included in the running count.
  a_match_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> (out_tdata[32:17] != '0))
    else $error("match reported with zero match count");

  // Input backpressure only comes from a stalled result.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_tready && (in_seen || !in_seen)) |-> out_tvalid)
    else $error("input stalled with no result waiting");

endmodule

bind glob_wildcard_matcher_core gwm_chk u_gwm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
